>>> hw/rtl/e2bv_pkg.sv
// Package: widths, CORDIC constants and helper functions for the Euler-to-basis block.
package e2bv_pkg;
    localparam int OutFracBits = 14;
    localparam int CordicSteps = 16;
    localparam int AngW = 16;
    localparam int OutW = 16;
    localparam int QW = 32;
    localparam int TurnUnits = 23040;
    localparam logic signed [QW-1:0] GainInv = 32'sd652032874;
    localparam logic signed [QW-1:0] OneQ30 = 32'sd1073741824;

    typedef logic signed [QW-1:0] t_q30;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'd536870912;
            1: v = 32'd316933405;
            2: v = 32'd167458907;
            3: v = 32'd85004756;
            4: v = 32'd42667331;
            5: v = 32'd21354465;
            6: v = 32'd10679838;
            7: v = 32'd5340245;
            8: v = 32'd2670163;
            9: v = 32'd1335086;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41721;
            15: v = 32'd20860;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2607;
            19: v = 32'd1303;
            20: v = 32'd651;
            21: v = 32'd325;
            22: v = 32'd162;
            23: v = 32'd81;
            24: v = 32'd40;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd2;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic t_q30 clamp_unit(input logic signed [QW+1:0] v);
        t_q30 r;
        if (v > 34'sd1073741824) r = OneQ30;
        else if (v < -34'sd1073741824) r = -OneQ30;
        else r = t_q30'(v);
        return r;
    endfunction

    // Q30 product rounded back to Q30
    function automatic logic signed [QW+1:0] qrnd(input logic signed [2*QW-1:0] p);
        logic signed [2*QW-1:0] s;
        s = (p + (64'sd1 <<< 29)) >>> 30;
        return s[QW+1:0];
    endfunction

    function automatic logic [OutW-1:0] to_out(input logic signed [QW+1:0] v);
        logic signed [QW-1:0] c;
        logic signed [QW-1:0] r;
        c = clamp_unit(v);
        if (OutFracBits < 30)
            r = (c + (t_q30'(1) <<< (29 - OutFracBits))) >>> (30 - OutFracBits);
        else
            r = c;
        return r[OutW-1:0];
    endfunction
endpackage

>>> hw/rtl/e2bv_sincos.sv
// Pipelined angle reduction and rotation-mode CORDIC giving cosine and sine in Q30.
module e2bv_sincos (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [15:0]        i_angle,
    output e2bv_pkg::t_q30            o_cos,
    output e2bv_pkg::t_q30            o_sin
);
    localparam int N = e2bv_pkg::CordicSteps;

    logic [14:0]        r_red;
    logic [37:0]        r_prod;
    logic [33:0]        r_est;
    logic [1:0]         r_q  [N+1];
    logic signed [33:0] r_x  [N+1];
    logic signed [33:0] r_y  [N+1];
    logic signed [32:0] r_z  [N+1];
    logic signed [16:0] n_mod;
    logic [37:0]        n_prod;
    logic [33:0]        n_est;
    logic [33:0]        n_t;
    e2bv_pkg::t_q30     n_c;
    e2bv_pkg::t_q30     n_s;

    always_comb begin
        n_mod = 17'(i_angle);
        if (n_mod < 0) n_mod = n_mod + 17'sd23040;
        if (n_mod < 0) n_mod = n_mod + 17'sd23040;
        if (n_mod >= 17'sd23040) n_mod = n_mod - 17'sd23040;
        n_prod = {r_red, 23'd0} + 38'd22;
        // divide by 45 through reciprocal, then correct in the next stage
        n_est = 34'((((72'(r_red) * 72'd1527099483) << 23) + 72'd33596188626) >> 36);
        n_t = r_est;
        if (40'(r_est + 34'd1) * 40'd45 <= 40'(r_prod)) n_t = r_est + 34'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red  <= n_mod[14:0];
            r_prod <= n_prod;
            r_est  <= n_est;
            r_q[0] <= n_t[31:30];
            r_x[0] <= 34'(e2bv_pkg::GainInv);
            r_y[0] <= '0;
            r_z[0] <= 33'({3'b000, n_t[29:0]});
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1] <= r_q[g];
                if (!r_z[g][32]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - 33'(e2bv_pkg::atan_turn(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + 33'(e2bv_pkg::atan_turn(g));
                end
            end
        end
    end

    always_comb begin
        n_c = e2bv_pkg::clamp_unit(r_x[N]);
        n_s = e2bv_pkg::clamp_unit(r_y[N]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[N])
                2'd0: begin o_cos <= n_c;  o_sin <= n_s;  end
                2'd1: begin o_cos <= -n_s; o_sin <= n_c;  end
                2'd2: begin o_cos <= -n_c; o_sin <= -n_s; end
                default: begin o_cos <= n_s; o_sin <= -n_c; end
            endcase
        end
    end
endmodule

>>> hw/rtl/euler_to_basis_vectors.sv
// Top level: Euler angles to forward, up and right basis vectors.
// channel | dir | tdata (low bit up)
// s_axis  | in  | angle_x, angle_y, angle_z (48 bits)
// m_axis  | out | fwd_xyz, up_xyz, side_xyz (144 bits)
// One word per cycle while the output is not stalled; a word passes through three angle
// stages, the CORDIC stage chain, the quadrant stage, two multiplier stages and the
// output register before it shows on m_axis. The whole pipe advances when the output
// register is empty or taken; reset clears only the valid bits.
module euler_to_basis_vectors (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // angle_x, angle_y, angle_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // fwd x,y,z, up x,y,z, side x,y,z
);
    localparam int Lat = e2bv_pkg::CordicSteps + 4;

    logic [Lat+2:0] r_vld;
    logic           n_en;
    e2bv_pkg::t_q30 cx, sx, cy, sy, cz, sz;
    logic signed [33:0] r_sxsy, r_cxsy, r_cycz, r_cxsz, r_sxsz, r_cysz, r_cxcz, r_sxcz;
    logic signed [33:0] r_sxcy, r_cxcy;
    e2bv_pkg::t_q30 r_cz2, r_sz2, r_sy2;
    logic signed [33:0] r_a1, r_a2, r_b1, r_b2, r_m0, r_m3, r_m6, r_m7, r_m8;
    logic signed [33:0] r_a0, r_b0, r_c0, r_d0;
    logic [143:0] r_data;

    assign n_en = !r_vld[Lat+2] || m_axis_tready;
    assign s_axis_tready = n_en;
    assign m_axis_tvalid = r_vld[Lat+2];
    assign m_axis_tdata  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[Lat+1:0], s_axis_tvalid};
        end
    end

    e2bv_sincos u_sx (.i_clk, .i_en(n_en), .i_angle(s_axis_tdata[15:0]),
                      .o_cos(cx), .o_sin(sx));
    e2bv_sincos u_sy (.i_clk, .i_en(n_en), .i_angle(s_axis_tdata[31:16]),
                      .o_cos(cy), .o_sin(sy));
    e2bv_sincos u_sz (.i_clk, .i_en(n_en), .i_angle(s_axis_tdata[47:32]),
                      .o_cos(cz), .o_sin(sz));

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            // first products
            r_sxsy <= e2bv_pkg::qrnd(64'(sx) * 64'(sy));
            r_cxsy <= e2bv_pkg::qrnd(64'(cx) * 64'(sy));
            r_cycz <= e2bv_pkg::qrnd(64'(cy) * 64'(cz));
            r_cxsz <= e2bv_pkg::qrnd(64'(cx) * 64'(sz));
            r_sxsz <= e2bv_pkg::qrnd(64'(sx) * 64'(sz));
            r_cysz <= e2bv_pkg::qrnd(64'(cy) * 64'(sz));
            r_cxcz <= e2bv_pkg::qrnd(64'(cx) * 64'(cz));
            r_sxcz <= e2bv_pkg::qrnd(64'(sx) * 64'(cz));
            r_sxcy <= e2bv_pkg::qrnd(64'(sx) * 64'(cy));
            r_cxcy <= e2bv_pkg::qrnd(64'(cx) * 64'(cy));
            r_cz2  <= cz;
            r_sz2  <= sz;
            r_sy2  <= sy;
            // second products
            r_a1 <= e2bv_pkg::qrnd(64'(r_sxsy) * 64'(r_cz2));
            r_a2 <= e2bv_pkg::qrnd(64'(r_cxsy) * 64'(r_cz2));
            r_b1 <= e2bv_pkg::qrnd(64'(r_sxsy) * 64'(r_sz2));
            r_b2 <= e2bv_pkg::qrnd(64'(r_cxsy) * 64'(r_sz2));
            r_a0 <= r_cxsz;
            r_b0 <= r_sxsz;
            r_c0 <= r_cxcz;
            r_d0 <= r_sxcz;
            r_m0 <= r_cycz;
            r_m3 <= -r_cysz;
            r_m6 <= 34'(r_sy2);
            r_m7 <= -r_sxcy;
            r_m8 <= r_cxcy;
            // sums and output rounding
            r_data <= {e2bv_pkg::to_out(r_m8), e2bv_pkg::to_out(r_m7),
                       e2bv_pkg::to_out(r_m6),
                       e2bv_pkg::to_out(r_b2 + r_d0), e2bv_pkg::to_out(r_c0 - r_b1),
                       e2bv_pkg::to_out(r_m3),
                       e2bv_pkg::to_out(r_b0 - r_a2), e2bv_pkg::to_out(r_a1 + r_a0),
                       e2bv_pkg::to_out(r_m0)};
        end
    end
endmodule

>>> hw/rtl/e2bv_checker.sv
// Port checker for the Euler-to-basis block and its bind.
module e2bv_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("stall with empty output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind euler_to_basis_vectors e2bv_checker u_chk (.i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

>>> tb/tb_euler_to_basis_vectors.sv
// Testbench for euler_to_basis_vectors: streamed angle words against a bit-exact predictor.
`timescale 1ns / 100ps

module tb_euler_to_basis_vectors;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam longint ATAN_LUT [32] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
        10, 5, 2, 1, 0, 0};
    localparam int DEG90 = 5760;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [47:0]   s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [143:0]  m_data;

    logic [47:0]   angle_words [$];
    logic [143:0]  basis_expected [$];
    int            send_idle = 0;
    int            recv_stall = 0;
    logic          hold_req = 1'b0;
    int            hold_cnt = 0;
    int            mismatches = 0;

    euler_to_basis_vectors i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // angle_x, angle_y, angle_z
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)     // fwd x,y,z, up x,y,z, side x,y,z
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_q30(longint v);
        if (v > UNIT_Q30) return UNIT_Q30;
        if (v < -UNIT_Q30) return -UNIT_Q30;
        return v;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [15:0] quantise(longint v);
        longint r;
        r = clamp_q30(v);
        if (e2bv_pkg::OutFracBits < 30)
            r = (r + (64'sd1 <<< (29 - e2bv_pkg::OutFracBits)))
                >>> (30 - e2bv_pkg::OutFracBits);
        return r[15:0];
    endfunction

    function automatic void angle_sin_cos(input logic [15:0] raw, output longint c,
                                          output longint s);
        longint a, z, x, y, dx, dy;
        longint unsigned ph;
        logic [1:0] quad;
        a = longint'($signed(raw));
        a = a % e2bv_pkg::TurnUnits;
        if (a < 0) a += e2bv_pkg::TurnUnits;
        ph = (longint'(a) * (64'd1 << 23) + 22) / 45;
        quad = ph[31:30];
        z = longint'(ph[29:0]);
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < e2bv_pkg::CordicSteps && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_LUT[i];
            end else begin
                x += dx; y -= dy; z += ATAN_LUT[i];
            end
        end
        x = clamp_q30(x);
        y = clamp_q30(y);
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [143:0] basis_of(logic [47:0] w);
        longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
        logic [143:0] r;
        angle_sin_cos(w[15:0], cx, sx);
        angle_sin_cos(w[31:16], cy, sy);
        angle_sin_cos(w[47:32], cz, sz);
        sxsy = mul_q30(sx, sy);
        cxsy = mul_q30(cx, sy);
        r[15:0]    = quantise(mul_q30(cy, cz));
        r[31:16]   = quantise(mul_q30(sxsy, cz) + mul_q30(cx, sz));
        r[47:32]   = quantise(-mul_q30(cxsy, cz) + mul_q30(sx, sz));
        r[63:48]   = quantise(-mul_q30(cy, sz));
        r[79:64]   = quantise(-mul_q30(sxsy, sz) + mul_q30(cx, cz));
        r[95:80]   = quantise(mul_q30(cxsy, sz) + mul_q30(sx, cz));
        r[111:96]  = quantise(sy);
        r[127:112] = quantise(-mul_q30(sx, cy));
        r[143:128] = quantise(mul_q30(cx, cy));
        return r;
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(DEG90 * $signed($urandom_range(8)) - 4 * DEG90
                          + $signed($urandom_range(8)) - 4);
            2: return 16'($signed($urandom_range(200)) - 100);
            default: return 16'($urandom_range(23039));
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                basis_expected.push_back(basis_of(s_data));
            if (!(s_valid && !s_ready)) begin
                if (angle_words.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_data  <= angle_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
        else if (hold_req) hold_cnt <= 400;
    end

    // monitor
    always @(posedge i_clk) begin
        logic [143:0] want;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                if (basis_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", m_data);
                end else begin
                    want = basis_expected.pop_front();
                    for (int f = 0; f < 9; f++) begin
                        if (m_data[f*16 +: 16] !== want[f*16 +: 16]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("field %0d: expected %0d got %0d", f,
                                         $signed(want[f*16 +: 16]),
                                         $signed(m_data[f*16 +: 16]));
                        end
                    end
                end
            end
            m_ready <= (hold_cnt == 0) && !hold_req && ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic drain();
        wait (angle_words.size() == 0 && !s_valid && basis_expected.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] dir_set [10] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd5760,
            16'sd11520, 16'sd17280, 16'sd23040, -16'sd5760, 16'sd2880, 16'sd5759};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 10; i++)
            angle_words.push_back({dir_set[(i + 2) % 10], dir_set[(i + 1) % 10], dir_set[i]});
        angle_words.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
        angle_words.push_back({16'h5555, 16'hAAAA, 16'h5555});
        angle_words.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
        angle_words.push_back({16'sd1, 16'sd5761, 16'sd11521});
        angle_words.push_back({16'sd17279, 16'sd11519, -16'sd1});
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1) ? 81 : (ph == 3) ? 35 : 0;
            recv_stall = (ph == 2) ? 81 : (ph == 3) ? 35 : 0;
            for (int i = 0; i < 200; i++)
                angle_words.push_back({rand_angle(), rand_angle(), rand_angle()});
            if (ph == 0) begin
                repeat (20) @(posedge i_clk);
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            drain();
        end
        repeat (e2bv_pkg::CordicSteps + 40) @(posedge i_clk);
        if (mismatches == 0 && basis_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
